// File: rtl/core/cbc_pkg.sv
// circle versus box collision: shared constants and the normal saturation helper
// no dependencies
`default_nettype none
package cbc_pkg;
   localparam int COORD_BITS_DEF  = 24;
   localparam int NORMAL_FRAC_DEF = 14;
   localparam int NORMAL_OUT_BITS = 16;

   localparam logic [31:0] NORM_POS_MAX = 32'((1 << (NORMAL_OUT_BITS - 1)) - 1);
   localparam logic [31:0] NORM_NEG_MAX = 32'(1 << (NORMAL_OUT_BITS - 1));

   // signed, saturated normal component from quotient magnitude and sign
   function automatic logic [NORMAL_OUT_BITS-1:0] sat_comp(input logic [31:0] mag,
                                                            input logic neg);
      logic [NORMAL_OUT_BITS-1:0] res;
      if (!neg) begin
         res = (mag > NORM_POS_MAX) ? NORM_POS_MAX[NORMAL_OUT_BITS-1:0]
                                    : mag[NORMAL_OUT_BITS-1:0];
      end else begin
         res = (mag > NORM_NEG_MAX) ? NORM_NEG_MAX[NORMAL_OUT_BITS-1:0]
                                    : NORMAL_OUT_BITS'(~mag[NORMAL_OUT_BITS-1:0] + 1'b1);
      end
      return res;
   endfunction
endpackage
`default_nettype wire

// File: rtl/core/cbc_req_if.sv
// request channel: circle and box of one query
// depends on cbc_pkg
`default_nettype none
interface cbc_req_if #(parameter int COORD_BITS = cbc_pkg::COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   logic        [COORD_BITS-2:0] radius;
   logic signed [COORD_BITS-1:0] box_left;
   logic signed [COORD_BITS-1:0] box_top;
   logic        [COORD_BITS-2:0] box_width;
   logic        [COORD_BITS-2:0] box_height;

   modport source (output valid, center_x, center_y, radius, box_left, box_top,
                   box_width, box_height, input ready);
   modport sink (input valid, center_x, center_y, radius, box_left, box_top,
                 box_width, box_height, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cbc_rsp_if.sv
// response channel: hit, penetration and push-out normal
// depends on cbc_pkg
`default_nettype none
interface cbc_rsp_if #(parameter int COORD_BITS = cbc_pkg::COORD_BITS_DEF);
   logic                                      valid;
   logic                                      ready;
   logic                                      hit;
   logic        [COORD_BITS-2:0]              penetration;
   logic signed [cbc_pkg::NORMAL_OUT_BITS-1:0] normal_x;
   logic signed [cbc_pkg::NORMAL_OUT_BITS-1:0] normal_y;

   modport source (output valid, hit, penetration, normal_x, normal_y, input ready);
   modport sink (input valid, hit, penetration, normal_x, normal_y, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cbc_sqrt_cell.sv
// one digit cell of the square root chain: one root bit per cell
// no package dependencies
`default_nettype none
module cbc_sqrt_cell #(
   parameter int CB     = 24,
   parameter int SIDE_W = 72
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [2*CB-1:0]   in_rad,
   input  wire logic [CB:0]       in_rem,
   input  wire logic [CB-1:0]     in_root,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [2*CB-1:0]        out_rad,
   output logic [CB:0]            out_rem,
   output logic [CB-1:0]          out_root,
   output logic [SIDE_W-1:0]      out_side
);
   logic              valid_ff;
   logic [2*CB-1:0]   rad_ff;
   logic [CB:0]       rem_ff;
   logic [CB-1:0]     root_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [CB+2:0]     rem_sh;
   logic [CB+2:0]     trial;
   logic              take;
   logic [CB:0]       rem_in;
   logic [CB-1:0]     root_in;

   always_comb begin
      rem_sh  = {in_rem, in_rad[2*CB-1 -: 2]};
      trial   = {1'b0, in_root, 2'b01};
      take    = (rem_sh >= trial);
      rem_in  = take ? (CB+1)'(rem_sh - trial) : rem_sh[CB:0];
      root_in = {in_root[CB-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         rad_ff  <= {in_rad[2*CB-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

// File: rtl/core/cbc_div_cell.sv
// one restoring division cell: one quotient bit for each normal component
// no package dependencies
`default_nettype none
module cbc_div_cell #(
   parameter int CB     = 24,
   parameter int QW     = 15,
   parameter int SIDE_W = 27
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [CB-1:0]     in_dist,
   input  wire logic [CB-1:0]     in_rem_x,
   input  wire logic [CB-1:0]     in_rem_y,
   input  wire logic [QW-1:0]     in_q_x,
   input  wire logic [QW-1:0]     in_q_y,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [CB-1:0]          out_dist,
   output logic [CB-1:0]          out_rem_x,
   output logic [CB-1:0]          out_rem_y,
   output logic [QW-1:0]          out_q_x,
   output logic [QW-1:0]          out_q_y,
   output logic [SIDE_W-1:0]      out_side
);
   logic              valid_ff;
   logic [CB-1:0]     dist_ff, rem_x_ff, rem_y_ff;
   logic [QW-1:0]     q_x_ff, q_y_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [CB:0]       t_x, t_y, d_ext;
   logic              take_x, take_y;

   always_comb begin
      t_x    = {in_rem_x, 1'b0};
      t_y    = {in_rem_y, 1'b0};
      d_ext  = {1'b0, in_dist};
      take_x = (t_x >= d_ext);
      take_y = (t_y >= d_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         dist_ff  <= in_dist;
         rem_x_ff <= take_x ? CB'(t_x - d_ext) : t_x[CB-1:0];
         rem_y_ff <= take_y ? CB'(t_y - d_ext) : t_y[CB-1:0];
         q_x_ff   <= {in_q_x[QW-2:0], take_x};
         q_y_ff   <= {in_q_y[QW-2:0], take_y};
         side_ff  <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_dist  = dist_ff;
   assign out_rem_x = rem_x_ff;
   assign out_rem_y = rem_y_ff;
   assign out_q_x   = q_x_ff;
   assign out_q_y   = q_y_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

// File: rtl/core/circle_box_collision.sv
// circle versus axis-aligned box collision, top level
// depends on cbc_pkg, cbc_req_if, cbc_rsp_if, cbc_sqrt_cell, cbc_div_cell
//
// channel  dir  payload
// req      in   center_x, center_y, radius, box_left, box_top, box_width, box_height
// rsp      out  hit, penetration, normal_x, normal_y
//
// one request per cycle while no response is held waiting
// the square root chain has one cell per root bit, the divider one per quotient bit after the first
// the whole pipeline advances together and holds while a response waits
// reset clears only the stage valid bits
`default_nettype none
module circle_box_collision #(
   parameter int COORD_BITS       = cbc_pkg::COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = cbc_pkg::NORMAL_FRAC_DEF
) (
   input wire logic clock,
   input wire logic reset,
   cbc_req_if.sink  req,
   cbc_rsp_if.source rsp
);
   localparam int CB     = COORD_BITS;
   localparam int NF     = NORMAL_FRAC_BITS;
   localparam int QW     = NF + 1;
   localparam int NO     = cbc_pkg::NORMAL_OUT_BITS;
   localparam int SQ_W   = 3 * CB;
   localparam int DV_W   = CB + 3;
   localparam logic [NO-1:0] NY_ZERO = NO'(~(32'd1 << NF) + 32'd1);
   localparam logic signed [NO-1:0] N_UNIT = NO'(32'd1 << NF);

   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   // stage 1: request register
   logic                 s1_valid_ff;
   logic signed [CB-1:0] s1_cx_ff, s1_cy_ff, s1_left_ff, s1_top_ff;
   logic        [CB-2:0] s1_r_ff, s1_w_ff, s1_h_ff;
   // stage 2: differences to the clamped point
   logic                 s2_valid_ff;
   logic signed [CB:0]   s2_dx_ff, s2_dy_ff;
   logic        [CB-2:0] s2_r_ff;
   // stage 3: magnitudes
   logic                 s3_valid_ff, s3_far_ff, s3_sx_ff, s3_sy_ff;
   logic        [CB-2:0] s3_adx_ff, s3_ady_ff, s3_r_ff;
   // stage 4: squares
   logic                 s4_valid_ff, s4_far_ff, s4_sx_ff, s4_sy_ff;
   logic        [CB-2:0] s4_adx_ff, s4_ady_ff, s4_r_ff;
   logic     [2*CB-3:0]  s4_sqx_ff, s4_sqy_ff;
   // stage 5: sum of squares
   logic                 s5_valid_ff;
   logic     [2*CB-1:0]  s5_sum_ff;
   logic     [SQ_W-1:0]  s5_side_ff;

   logic signed [CB:0] x_lo, x_hi, y_lo, y_hi, cx_e, cy_e, px, py;
   logic        [CB:0] adx_w, ady_w;

   always_comb begin
      cx_e = (CB+1)'(s1_cx_ff);
      cy_e = (CB+1)'(s1_cy_ff);
      x_lo = (CB+1)'(s1_left_ff);
      y_lo = (CB+1)'(s1_top_ff);
      x_hi = x_lo + $signed({2'b00, s1_w_ff});
      y_hi = y_lo + $signed({2'b00, s1_h_ff});
      priority if (cx_e < x_lo) px = x_lo;
      else if (cx_e > x_hi)     px = x_hi;
      else                      px = cx_e;
      priority if (cy_e < y_lo) py = y_lo;
      else if (cy_e > y_hi)     py = y_hi;
      else                      py = cy_e;
      adx_w = s2_dx_ff[CB] ? (CB+1)'(-s2_dx_ff) : s2_dx_ff;
      ady_w = s2_dy_ff[CB] ? (CB+1)'(-s2_dy_ff) : s2_dy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
      if (en) begin
         s1_cx_ff   <= req.center_x;
         s1_cy_ff   <= req.center_y;
         s1_r_ff    <= req.radius;
         s1_left_ff <= req.box_left;
         s1_top_ff  <= req.box_top;
         s1_w_ff    <= req.box_width;
         s1_h_ff    <= req.box_height;

         s2_dx_ff <= (CB+1)'(cx_e - px);
         s2_dy_ff <= (CB+1)'(cy_e - py);
         s2_r_ff  <= s1_r_ff;

         s3_far_ff <= adx_w[CB] || adx_w[CB-1] || ady_w[CB] || ady_w[CB-1];
         s3_sx_ff  <= s2_dx_ff[CB];
         s3_sy_ff  <= s2_dy_ff[CB];
         s3_adx_ff <= adx_w[CB-2:0];
         s3_ady_ff <= ady_w[CB-2:0];
         s3_r_ff   <= s2_r_ff;

         s4_far_ff <= s3_far_ff;
         s4_sx_ff  <= s3_sx_ff;
         s4_sy_ff  <= s3_sy_ff;
         s4_adx_ff <= s3_adx_ff;
         s4_ady_ff <= s3_ady_ff;
         s4_r_ff   <= s3_r_ff;
         s4_sqx_ff <= s3_adx_ff * s3_adx_ff;
         s4_sqy_ff <= s3_ady_ff * s3_ady_ff;

         s5_sum_ff  <= (2*CB)'(s4_sqx_ff) + (2*CB)'(s4_sqy_ff);
         s5_side_ff <= {s4_r_ff, s4_sx_ff, s4_sy_ff, s4_far_ff, s4_adx_ff, s4_ady_ff};
      end
   end

   // square root chain
   logic [CB:0]         sq_valid;
   logic [2*CB-1:0]     sq_rad  [CB+1];
   logic [CB:0]         sq_rem  [CB+1];
   logic [CB-1:0]       sq_root [CB+1];
   logic [SQ_W-1:0]     sq_side [CB+1];

   assign sq_valid[0] = s5_valid_ff;
   assign sq_rad[0]   = s5_sum_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_side[0]  = s5_side_ff;

   for (genvar i = 0; i < CB; i++) begin : g_sqrt
      cbc_sqrt_cell #(.CB(CB), .SIDE_W(SQ_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (sq_valid[i]),
         .in_rad   (sq_rad[i]),
         .in_rem   (sq_rem[i]),
         .in_root  (sq_root[i]),
         .in_side  (sq_side[i]),
         .out_valid(sq_valid[i+1]),
         .out_rad  (sq_rad[i+1]),
         .out_rem  (sq_rem[i+1]),
         .out_root (sq_root[i+1]),
         .out_side (sq_side[i+1])
      );
   end

   // stage 6: hit test and first quotient bit
   logic [CB-1:0] dist_w;
   logic [CB-2:0] t_r, t_adx, t_ady;
   logic          t_sx, t_sy, t_far, t_zero, t_hit, t_q0x, t_q0y;
   logic [CB-2:0] t_pen;

   always_comb begin
      dist_w = sq_root[CB];
      {t_r, t_sx, t_sy, t_far, t_adx, t_ady} = sq_side[CB];
      t_zero = (dist_w == '0);
      t_hit  = !t_far && (t_zero || (dist_w < {1'b0, t_r}));
      t_pen  = t_zero ? t_r : (CB-1)'({1'b0, t_r} - dist_w);
      t_q0x  = ({1'b0, t_adx} == dist_w);
      t_q0y  = ({1'b0, t_ady} == dist_w);
   end

   logic                s6_valid_ff;
   logic [CB-1:0]       s6_dist_ff, s6_rem_x_ff, s6_rem_y_ff;
   logic [QW-1:0]       s6_q_x_ff, s6_q_y_ff;
   logic [DV_W-1:0]     s6_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s6_valid_ff <= sq_valid[CB];
      end
      if (en) begin
         s6_dist_ff  <= dist_w;
         s6_rem_x_ff <= t_q0x ? '0 : {1'b0, t_adx};
         s6_rem_y_ff <= t_q0y ? '0 : {1'b0, t_ady};
         s6_q_x_ff   <= QW'(t_q0x);
         s6_q_y_ff   <= QW'(t_q0y);
         s6_side_ff  <= {t_hit, t_zero, t_pen, t_sx, t_sy};
      end
   end

   // division chain
   logic [NF:0]     dv_valid;
   logic [CB-1:0]   dv_dist  [NF+1];
   logic [CB-1:0]   dv_rem_x [NF+1];
   logic [CB-1:0]   dv_rem_y [NF+1];
   logic [QW-1:0]   dv_q_x   [NF+1];
   logic [QW-1:0]   dv_q_y   [NF+1];
   logic [DV_W-1:0] dv_side  [NF+1];

   assign dv_valid[0] = s6_valid_ff;
   assign dv_dist[0]  = s6_dist_ff;
   assign dv_rem_x[0] = s6_rem_x_ff;
   assign dv_rem_y[0] = s6_rem_y_ff;
   assign dv_q_x[0]   = s6_q_x_ff;
   assign dv_q_y[0]   = s6_q_y_ff;
   assign dv_side[0]  = s6_side_ff;

   for (genvar j = 0; j < NF; j++) begin : g_div
      cbc_div_cell #(.CB(CB), .QW(QW), .SIDE_W(DV_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (dv_valid[j]),
         .in_dist  (dv_dist[j]),
         .in_rem_x (dv_rem_x[j]),
         .in_rem_y (dv_rem_y[j]),
         .in_q_x   (dv_q_x[j]),
         .in_q_y   (dv_q_y[j]),
         .in_side  (dv_side[j]),
         .out_valid(dv_valid[j+1]),
         .out_dist (dv_dist[j+1]),
         .out_rem_x(dv_rem_x[j+1]),
         .out_rem_y(dv_rem_y[j+1]),
         .out_q_x  (dv_q_x[j+1]),
         .out_q_y  (dv_q_y[j+1]),
         .out_side (dv_side[j+1])
      );
   end

   // output register
   logic          f_hit, f_zero, f_sx, f_sy;
   logic [CB-2:0] f_pen;
   logic [NO-1:0] f_nx, f_ny;

   always_comb begin
      {f_hit, f_zero, f_pen, f_sx, f_sy} = dv_side[NF];
      f_nx = cbc_pkg::sat_comp(32'(dv_q_x[NF]), f_sx);
      f_ny = cbc_pkg::sat_comp(32'(dv_q_y[NF]), f_sy);
   end

   logic          rsp_hit_ff;
   logic [CB-2:0] rsp_pen_ff;
   logic [NO-1:0] rsp_nx_ff, rsp_ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid[NF];
      end
      if (en) begin
         rsp_hit_ff <= f_hit;
         rsp_pen_ff <= f_hit ? f_pen : '0;
         rsp_nx_ff  <= (!f_hit || f_zero) ? '0 : f_nx;
         rsp_ny_ff  <= !f_hit ? '0 : (f_zero ? NY_ZERO : f_ny);
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.hit         = rsp_hit_ff;
   assign rsp.penetration = rsp_pen_ff;
   assign rsp.normal_x    = rsp_nx_ff;
   assign rsp.normal_y    = rsp_ny_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.hit |-> rsp.penetration == '0 && rsp.normal_x == '0
                                && rsp.normal_y == '0)
      else $error("miss carries non-zero payload");

   a_normal_unit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.hit |-> rsp.normal_x <= N_UNIT && rsp.normal_x >= -N_UNIT
                               && rsp.normal_y <= N_UNIT && rsp.normal_y >= -N_UNIT)
      else $error("normal component beyond unit length");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid && !s1_valid_ff && !s6_valid_ff)
      else $error("pipeline not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(s6_valid_ff) && $stable(s1_valid_ff))
      else $error("pipeline moved while stalled");
endmodule
`default_nettype wire
